// ----- sv/svg_pkg.sv -----
package svg_pkg;

   // Fixed-point format of every value
   localparam int FRAC_BITS = 16;
   localparam int R_BITS    = 30;

   // Lag square root: one result bit per cell
   localparam int SQRT_STEPS = 32;
   // Quotient r = h * 2^R_BITS / range: one quotient bit per cell
   localparam int DIV_STEPS  = 31;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_NUGGET = 2'd0;
   localparam logic [1:0] CSR_SILL   = 2'd1;
   localparam logic [1:0] CSR_RANGE  = 2'd2;

   // Integer square root for reset values worked out at elaboration
   function automatic longint unsigned isqrt_const(input longint unsigned x);
      longint unsigned op;
      longint unsigned res;
      longint unsigned one;
      op  = x;
      res = 0;
      one = 64'd1 << 62;
      while (one != 0) begin
         if (op >= res + one) begin
            op  = op - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   localparam longint unsigned NUGGET_RESET_WIDE =
      (((64'd1 << (FRAC_BITS + 1)) / 5) + 64'd1) >> 1;
   localparam longint unsigned SILL_RESET_WIDE = 64'd1 << FRAC_BITS;
   localparam longint unsigned RANGE_RESET_WIDE =
      (isqrt_const(64'd3 << (2 * FRAC_BITS + 2)) + 64'd1) >> 1;

   localparam logic signed [31:0] NUGGET_RESET = NUGGET_RESET_WIDE[31:0];
   localparam logic signed [31:0] SILL_RESET   = SILL_RESET_WIDE[31:0];
   localparam logic [30:0]        RANGE_RESET  = RANGE_RESET_WIDE[30:0];

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] semivariance;
      logic signed [31:0] covariance;
      logic               beyond_range;
   } rsp_type;

   // Control that travels with each request down the chain
   typedef struct packed {
      logic valid;
      logic beyond;
   } trail_type;

endpackage

// ----- sv/svg_sqrt_cell.sv -----
module svg_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic [4:0]       step,
   input  svg_pkg::trail_type trail_in,
   input  logic [63:0]      op_in,
   input  logic [63:0]      res_in,
   output svg_pkg::trail_type trail_out,
   output logic [63:0]      op_out,
   output logic [63:0]      res_out
);

   svg_pkg::trail_type trail_ff;
   logic [63:0] op_ff, op_in_next;
   logic [63:0] res_ff, res_in_next;
   logic [63:0] one;
   logic [63:0] trial;

   // Try one result bit: the weight falls by four each cell
   assign one   = 64'd1 << (6'd62 - {step, 1'b0});
   assign trial = res_in + one;

   always_comb begin
      if (op_in >= trial) begin
         op_in_next  = op_in - trial;
         res_in_next = (res_in >> 1) + one;
      end else begin
         op_in_next  = op_in;
         res_in_next = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trail_ff <= '0;
      end else begin
         trail_ff <= trail_in;
      end
      op_ff  <= op_in_next;
      res_ff <= res_in_next;
   end

   assign trail_out = trail_ff;
   assign op_out    = op_ff;
   assign res_out   = res_ff;

endmodule

// ----- sv/svg_div_cell.sv -----
module svg_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic [30:0]      range_length,
   input  svg_pkg::trail_type trail_in,
   input  logic [30:0]      rem_in,
   input  logic [30:0]      low_in,
   input  logic [30:0]      quo_in,
   output svg_pkg::trail_type trail_out,
   output logic [30:0]      rem_out,
   output logic [30:0]      low_out,
   output logic [30:0]      quo_out
);

   svg_pkg::trail_type trail_ff;
   logic [30:0] rem_ff, low_ff, quo_ff;
   logic [31:0] shifted;
   logic [31:0] diff;
   logic        fits;

   // Bring down the next dividend bit and subtract the range if it fits
   assign shifted = {rem_in, low_in[30]};
   assign diff    = shifted - {1'b0, range_length};
   assign fits    = shifted >= {1'b0, range_length};

   always_ff @(posedge clock) begin
      if (reset) begin
         trail_ff <= '0;
      end else begin
         trail_ff <= trail_in;
      end
      rem_ff <= fits ? diff[30:0] : shifted[30:0];
      low_ff <= {low_in[29:0], 1'b0};
      quo_ff <= {quo_in[29:0], fits};
   end

   assign trail_out = trail_ff;
   assign rem_out   = rem_ff;
   assign low_out   = low_ff;
   assign quo_out   = quo_ff;

endmodule

// ----- sv/svg_tail.sv -----
module svg_tail (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] nugget_level,
   input  logic signed [31:0] sill_level,
   input  svg_pkg::trail_type trail_in,
   input  logic [30:0]        ratio,
   output logic               rsp_valid,
   output svg_pkg::rsp_type   rsp_payload
);

   svg_pkg::trail_type trail1_ff, trail2_ff, trail3_ff, trail4_ff;
   logic [30:0]        r1_ff, r2r_ff;
   logic [61:0]        rr_ff;
   logic [61:0]        r3w_ff;
   logic [30:0]        p_ff;
   logic signed [63:0] t_ff;
   logic               valid_ff;
   svg_pkg::rsp_type   rsp_ff;

   logic [31:0]        r2;
   logic [31:0]        r3;
   logic [32:0]        poly;
   logic signed [32:0] span;
   logic signed [63:0] rounded;
   logic signed [34:0] gamma;
   logic signed [34:0] cov;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   assign r2   = rr_ff[61:30];
   assign r3   = r3w_ff[61:30];
   assign poly = ({2'b0, r2r_ff} + {1'b0, r2r_ff, 1'b0}) - {1'b0, r3};
   assign span = 33'(sill_level) - 33'(nugget_level);

   // Round to nearest, ties upward, then add the nugget back
   assign rounded = (t_ff + 64'sd536870912) >>> 30;
   assign gamma   = 35'($signed(rounded[33:0])) + 35'(nugget_level);
   assign cov     = 35'(sill_level) - gamma;

   always_ff @(posedge clock) begin
      if (reset) begin
         trail1_ff <= '0;
         trail2_ff <= '0;
         trail3_ff <= '0;
         trail4_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         trail1_ff <= trail_in;
         trail2_ff <= trail1_ff;
         trail3_ff <= trail2_ff;
         trail4_ff <= trail3_ff;
         valid_ff  <= trail4_ff.valid;
      end
      // r squared
      r1_ff  <= ratio;
      rr_ff  <= 62'(ratio) * 62'(ratio);
      // r cubed
      r2r_ff <= r1_ff;
      r3w_ff <= 62'(r2[30:0]) * 62'(r1_ff);
      // 1.5 r - 0.5 r^3
      p_ff   <= poly[31:1];
      // scale by sill minus nugget
      t_ff   <= 64'(span) * $signed({33'b0, p_ff});
      // saturate and hold the result for one cycle
      if (trail4_ff.beyond) begin
         rsp_ff.semivariance <= sill_level;
         rsp_ff.covariance   <= '0;
      end else begin
         rsp_ff.semivariance <= sat32(gamma);
         rsp_ff.covariance   <= sat32(cov);
      end
      rsp_ff.beyond_range <= trail4_ff.beyond;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/spherical_variogram_eval.sv -----
// Spherical variogram evaluator. Takes one request (offset pair) every cycle and
// returns semivariance, covariance and the beyond-range flag, strobed on
// rsp_valid for one cycle; busy is always low and the receiver cannot stall.
// The pipeline is the 32-cell square-root chain and the 31-cell division chain
// (one bit per cell), plus three input stages and five polynomial and output
// stages. Nugget, sill and range are written through the csr_ port and must
// only change while no request is in flight.
module spherical_variogram_eval (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  svg_pkg::req_type req_payload,
   output logic             rsp_valid,
   output svg_pkg::rsp_type rsp_payload,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_write_data
);

   logic signed [31:0] nugget_ff, sill_ff;
   logic [30:0]        range_ff;
   logic [61:0]        range_sq_ff;

   logic               v0_ff, v1_ff;
   logic [31:0]        mx_ff, my_ff;
   logic [63:0]        sx_ff, sy_ff;
   svg_pkg::trail_type in_trail;
   logic [63:0]        sum;
   logic [63:0]        sum_ff;
   logic               beyond_ff, v2_ff;

   svg_pkg::trail_type sq_trail [svg_pkg::SQRT_STEPS+1];
   logic [63:0]        sq_op    [svg_pkg::SQRT_STEPS+1];
   logic [63:0]        sq_res   [svg_pkg::SQRT_STEPS+1];

   svg_pkg::trail_type dv_trail [svg_pkg::DIV_STEPS+1];
   logic [30:0]        dv_rem   [svg_pkg::DIV_STEPS+1];
   logic [30:0]        dv_low   [svg_pkg::DIV_STEPS+1];
   logic [30:0]        dv_quo   [svg_pkg::DIV_STEPS+1];

   logic [31:0]        lag;
   logic [30:0]        ratio;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         nugget_ff <= svg_pkg::NUGGET_RESET;
         sill_ff   <= svg_pkg::SILL_RESET;
         range_ff  <= svg_pkg::RANGE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            svg_pkg::CSR_NUGGET: nugget_ff <= csr_write_data;
            svg_pkg::CSR_SILL:   sill_ff   <= csr_write_data;
            svg_pkg::CSR_RANGE:  range_ff  <= csr_write_data[30:0];
            default: ;
         endcase
      end
      range_sq_ff <= 62'(range_ff) * 62'(range_ff);
   end

   assign busy = 1'b0;

   // Magnitudes, squares, then the exact range test
   assign sum = sx_ff + sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      mx_ff     <= req_payload.offset_x[31] ? 32'(-req_payload.offset_x)
                                            : req_payload.offset_x;
      my_ff     <= req_payload.offset_y[31] ? 32'(-req_payload.offset_y)
                                            : req_payload.offset_y;
      sx_ff     <= 64'(mx_ff) * 64'(mx_ff);
      sy_ff     <= 64'(my_ff) * 64'(my_ff);
      sum_ff    <= sum;
      beyond_ff <= sum > {2'b0, range_sq_ff};
   end

   assign in_trail.valid  = v2_ff;
   assign in_trail.beyond = beyond_ff;

   // Square-root chain
   assign sq_trail[0] = in_trail;
   assign sq_op[0]    = sum_ff;
   assign sq_res[0]   = '0;

   for (genvar i = 0; i < svg_pkg::SQRT_STEPS; i++) begin : g_sqrt
      svg_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (5'(i)),
         .trail_in  (sq_trail[i]),
         .op_in     (sq_op[i]),
         .res_in    (sq_res[i]),
         .trail_out (sq_trail[i+1]),
         .op_out    (sq_op[i+1]),
         .res_out   (sq_res[i+1])
      );
   end

   // Division chain: r = lag * 2^30 / range
   assign lag         = sq_res[svg_pkg::SQRT_STEPS][31:0];
   assign dv_trail[0] = sq_trail[svg_pkg::SQRT_STEPS];
   assign dv_rem[0]   = lag[31:1];
   assign dv_low[0]   = {lag[0], 30'b0};
   assign dv_quo[0]   = '0;

   for (genvar j = 0; j < svg_pkg::DIV_STEPS; j++) begin : g_div
      svg_div_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .range_length (range_ff),
         .trail_in     (dv_trail[j]),
         .rem_in       (dv_rem[j]),
         .low_in       (dv_low[j]),
         .quo_in       (dv_quo[j]),
         .trail_out    (dv_trail[j+1]),
         .rem_out      (dv_rem[j+1]),
         .low_out      (dv_low[j+1]),
         .quo_out      (dv_quo[j+1])
      );
   end

   // Zero range: only zero lag is within range, taken as r = 0
   assign ratio = (range_ff == '0) ? '0 : dv_quo[svg_pkg::DIV_STEPS];

   svg_tail u_tail (
      .clock        (clock),
      .reset        (reset),
      .nugget_level (nugget_ff),
      .sill_level   (sill_ff),
      .trail_in     (dv_trail[svg_pkg::DIV_STEPS]),
      .ratio        (ratio),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ----- test/tb_spherical_variogram_eval.sv -----
module tb_spherical_variogram_eval;
   import svg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 90;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_payload;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_write_en;
   logic [1:0]       csr_index;
   logic [31:0]      csr_write_data;

   // Register copies used by the predictor
   longint           nugget_cfg;
   longint           sill_cfg;
   longint unsigned  range_cfg;

   req_type          pending_q[$];
   rsp_type          gamma_q[$];
   int               pushed_count;
   int               accepted_count;
   int               mismatch_count;
   int               quiet_cycles;
   bit               idle_off;

   spherical_variogram_eval i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Largest root whose square does not exceed the value, one bit at a time
   function automatic longint unsigned lag_root(input longint unsigned val);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= val) root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic rsp_type variogram_predict(input req_type rq);
      rsp_type         res;
      longint          sx;
      longint          sy;
      longint unsigned mx;
      longint unsigned my;
      longint unsigned lag_sq;
      longint unsigned lag;
      longint unsigned r;
      longint unsigned r2;
      longint unsigned r3;
      longint unsigned poly;
      longint          prod;
      longint          gamma;
      sx = rq.offset_x;
      sy = rq.offset_y;
      mx = (sx < 0) ? -sx : sx;
      my = (sy < 0) ? -sy : sy;
      lag_sq = mx * mx + my * my;
      if (lag_sq > range_cfg * range_cfg) begin
         res.semivariance = clip32(sill_cfg);
         res.covariance   = '0;
         res.beyond_range = 1'b1;
         return res;
      end
      lag = lag_root(lag_sq);
      r = 0;
      if (range_cfg != 0) r = (lag << R_BITS) / range_cfg;
      if (r > (64'd1 << R_BITS)) r = 64'd1 << R_BITS;
      r2 = (r * r) >> R_BITS;
      r3 = (r2 * r) >> R_BITS;
      poly = (3 * r - r3) >> 1;
      prod = (sill_cfg - nugget_cfg) * longint'(poly);
      gamma = ((prod + (64'sd1 <<< (R_BITS - 1))) >>> R_BITS) + nugget_cfg;
      res.semivariance = clip32(gamma);
      res.covariance   = clip32(sill_cfg - gamma);
      res.beyond_range = 1'b0;
      return res;
   endfunction

   // Driver: hold a request while busy, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            gamma_q.push_back(variogram_predict(req_payload));
            accepted_count++;
         end
         if (pending_q.size() != 0 && (idle_off || $urandom_range(99) >= 14)) begin
            start       <= 1'b1;
            req_payload <= pending_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (gamma_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_payload);
         end else begin
            rsp_type want;
            want = gamma_q.pop_front();
            if (want !== rsp_payload) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: semi exp %h got %h, cov exp %h got %h, beyond exp %b got %b",
                           want.semivariance, rsp_payload.semivariance,
                           want.covariance, rsp_payload.covariance,
                           want.beyond_range, rsp_payload.beyond_range);
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_NUGGET: nugget_cfg = longint'(signed'(data));
         CSR_SILL:   sill_cfg   = longint'(signed'(data));
         CSR_RANGE:  range_cfg  = data[30:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_model(input logic [31:0] nug, input logic [31:0] sil,
                            input logic [30:0] rng);
      csr_write(CSR_NUGGET, nug);
      csr_write(CSR_SILL, sil);
      csr_write(CSR_RANGE, {1'b0, rng});
   endtask

   // Wait until every request is in and every result is back
   task automatic drain();
      while (pushed_count != accepted_count || gamma_q.size() != 0 || start)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_offsets(input logic [31:0] x, input logic [31:0] y);
      req_type rq;
      rq.offset_x = x;
      rq.offset_y = y;
      pending_q.push_back(rq);
      pushed_count++;
   endtask

   function automatic logic [31:0] random_offset();
      logic [31:0] mag;
      case ($urandom_range(3))
         0: mag = $urandom();
         1: mag = $urandom_range(range_cfg[30:0]);
         2: mag = $urandom_range(255);
         default: mag = range_cfg[31:0] + $urandom_range(2) - 1;
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   task automatic random_burst(input int count);
      for (int n = 0; n < count; n++) begin
         // One pair in four is near-axis to keep the boundary busy
         if ($urandom_range(3) == 0) push_offsets(random_offset(), $urandom_range(3));
         else push_offsets(random_offset(), random_offset());
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_NUGGET;
      csr_write_data = '0;
      pushed_count   = 0;
      accepted_count = 0;
      mismatch_count = 0;
      idle_off       = 1'b0;
      nugget_cfg     = longint'(NUGGET_RESET);
      sill_cfg       = longint'(SILL_RESET);
      range_cfg      = RANGE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset values, zero lag, extremes and the range boundary
      push_offsets(32'd0, 32'd0);
      push_offsets(32'h80000000, 32'h80000000);
      push_offsets(32'h7FFFFFFF, 32'h7FFFFFFF);
      push_offsets(32'h80000000, 32'd0);
      push_offsets(32'd0, 32'h7FFFFFFF);
      push_offsets(RANGE_RESET, 32'd0);
      push_offsets(RANGE_RESET + 1, 32'd0);
      push_offsets(-RANGE_RESET, 32'd0);
      push_offsets(32'd0, -(RANGE_RESET + 1));
      push_offsets(32'd1, 32'hFFFFFFFF);
      push_offsets(32'h55555555, 32'hAAAAAAAA);
      push_offsets(32'h00010000, 32'h00010000);
      push_offsets(32'hFFFF8000, 32'h00008000);
      random_burst(40);
      // Pause until every result is back, then carry on
      drain();
      random_burst(40);
      drain();

      // Largest range with saturating nugget and sill
      set_model(32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF);
      push_offsets(32'd0, 32'd0);
      push_offsets(32'h7FFFFFFF, 32'd0);
      push_offsets(32'h80000000, 32'h80000000);
      random_burst(100);
      drain();

      set_model(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
      idle_off = 1'b1;
      random_burst(100);
      drain();
      idle_off = 1'b0;

      // Smallest range: only zero lag or a lag of one stays within
      set_model(32'd0, 32'h00010000, 31'd1);
      push_offsets(32'd0, 32'd0);
      push_offsets(32'd1, 32'd0);
      push_offsets(32'd1, 32'd1);
      random_burst(80);
      drain();

      // Nugget equal to sill
      set_model(32'h00020000, 32'h00020000, 31'h00030000);
      random_burst(90);
      drain();

      for (int ph = 0; ph < 2; ph++) begin
         set_model($urandom(), $urandom(), $urandom_range(31'h7FFFFFFF, 1));
         random_burst(100);
         drain();
      end

      if (mismatch_count == 0 && gamma_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/svg_pkg.sv
sv/svg_sqrt_cell.sv
sv/svg_div_cell.sv
sv/svg_tail.sv
sv/spherical_variogram_eval.sv
test/tb_spherical_variogram_eval.sv
